### sv/mexp_pkg.sv
// Package for the modular exponentiation block: field widths, default operand
// width and the sequencer state type. No dependencies.
package mexp_pkg;

   // Every field on the ports is 32 bits wide.
   localparam int FIELD_WIDTH           = 32;
   localparam int DEFAULT_OPERAND_WIDTH = 32;

   typedef enum logic [2:0] {
      ST_IDLE,   // waiting for a request transaction
      ST_RED,    // reducing the base modulo the modulus
      ST_NEXT,   // inspecting the next exponent bit
      ST_MUL,    // result times base
      ST_SQR,    // base squared
      ST_DONE    // handing the result to the output register
   } mexp_state_type;

endpackage

### sv/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer and bit-serial
// modular multiplier. Depends on mexp_pkg.
//
// Usage
//    The modulus is written through the csr_ channel (csr_data, 32 bits) while
//    the block is idle; reset sets it to 1 and a value of zero is taken as
//    2 to the power OPERAND_WIDTH. A request transaction carries the base in
//    req_tdata[31:0] and the exponent in req_tdata[63:32]; one response
//    transaction follows with the base raised to the exponent, reduced by the
//    modulus, in rsp_tdata[31:0]. An exponent of zero always gives 1.
//    Each modular multiplication shifts one multiplier bit per cycle. A request
//    is accepted, the base is reduced, then for each exponent bit up to the
//    highest set one the bit is inspected, the result is multiplied by the base
//    when the bit is set and the base is squared, and then the result is handed on.
//    One request is worked on at a time; req_tready is high only while idle.
//    The result sits in an output register, so a new request is taken while
//    an earlier response is still waiting; if the receiver stalls that long,
//    the finished result waits in the sequencer until the register frees.
//    Reset (synchronous, active high) drops any work and any pending response.
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = mexp_pkg::DEFAULT_OPERAND_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration: modulus
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0]      csr_data,
   // Request: [31:0] base_value, [63:32] exponent
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [2*mexp_pkg::FIELD_WIDTH-1:0]    req_tdata,
   // Response: [31:0] power_result
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mexp_pkg::FIELD_WIDTH-1:0]      rsp_tdata
);
   import mexp_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int CW = $clog2(W);

   mexp_state_type state_ff, state_in;

   logic [W-1:0]  mod_ff,  mod_in;
   logic [W-1:0]  base_ff, base_in;
   logic [W-1:0]  exp_ff,  exp_in;
   logic [W-1:0]  acc_ff,  acc_in;
   // Multiplier: scan_ff is shifted out MSB first, addend_ff is added on each
   // set bit, rem_ff holds the partial product, always below the modulus.
   logic [W-1:0]  scan_ff,   scan_in;
   logic [W-1:0]  addend_ff, addend_in;
   logic [W-1:0]  rem_ff,    rem_in;
   logic [CW-1:0] cnt_ff,    cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_data_ff,  rsp_data_in;

   logic [W:0]    mod_ext;
   logic [W+1:0]  step_sum;
   logic [W+2:0]  diff_one;
   logic [W+2:0]  diff_two;
   logic [W-1:0]  step_rem;
   logic          mul_last;
   logic          out_free;

   // A zero modulus stands for 2^W, so reduction keeps the low W bits.
   assign mod_ext = (mod_ff == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_ff};

   // One multiplier step: 2r + bit*addend is below three times the modulus,
   // so subtracting once or twice brings it back into range.
   assign step_sum = {1'b0, rem_ff, 1'b0} + (scan_ff[W-1] ? {2'b00, addend_ff} : '0);
   assign diff_one = {1'b0, step_sum} - {2'b00, mod_ext};
   assign diff_two = {1'b0, step_sum} - {1'b0, mod_ext, 1'b0};

   always_comb begin
      priority if (!diff_two[W+2]) begin
         step_rem = diff_two[W-1:0];
      end else if (!diff_one[W+2]) begin
         step_rem = diff_one[W-1:0];
      end else begin
         step_rem = step_sum[W-1:0];
      end
   end

   assign mul_last = (cnt_ff == CW'(W - 1));
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RED;
         end
         ST_RED: begin
            if (mul_last) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            priority if (exp_ff == '0) state_in = ST_DONE;
            else if (exp_ff[0])       state_in = ST_MUL;
            else                      state_in = ST_SQR;
         end
         ST_MUL: begin
            if (mul_last) state_in = ST_SQR;
         end
         ST_SQR: begin
            if (mul_last) state_in = ST_NEXT;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      csr_ready    = 1'b1;
      mod_in       = (csr_valid) ? csr_data[W-1:0] : mod_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      scan_in      = {scan_ff[W-2:0], 1'b0};
      addend_in    = addend_ff;
      rem_in       = step_rem;
      cnt_in       = cnt_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // The base is reduced by multiplying it by one.
            base_in   = req_tdata[W-1:0];
            exp_in    = req_tdata[FIELD_WIDTH +: W];
            acc_in    = W'(1);
            scan_in   = req_tdata[W-1:0];
            addend_in = W'(1);
            rem_in    = '0;
            cnt_in    = '0;
         end
         ST_RED: begin
            if (mul_last) base_in = step_rem;
         end
         ST_NEXT: begin
            // Result times base scans the result, whose value may equal a
            // modulus of one; the addend is the base, always reduced.
            scan_in   = exp_ff[0] ? acc_ff : base_ff;
            addend_in = base_ff;
            rem_in    = '0;
            cnt_in    = '0;
         end
         ST_MUL: begin
            if (mul_last) begin
               acc_in    = step_rem;
               scan_in   = base_ff;
               addend_in = base_ff;
               rem_in    = '0;
               cnt_in    = '0;
            end
         end
         ST_SQR: begin
            if (mul_last) begin
               base_in = step_rem;
               exp_in  = {1'b0, exp_ff[W-1:1]};
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mod_ff       <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      scan_ff     <= scan_in;
      addend_ff   <= addend_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = FIELD_WIDTH'(rsp_data_ff);

endmodule

### sv/mexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top
// level. Depends on mexp_pkg and modular_exponentiation.
module mexp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [mexp_pkg::FIELD_WIDTH-1:0]      rsp_tdata
);
   import mexp_pkg::*;

   // Reset drops any pending response.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response still valid after reset");

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Once a request is taken the block is busy with it.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A new response only follows a busy period.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without work");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
